/* src/ac3_shp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and decode tables for the AC-3 sync header probe.
// No dependencies.
package ac3_shp_pkg;

  localparam int          BUFFER_BYTES_DEF = 4096;
  localparam int          JOB_DEPTH_DEF    = 2;
  localparam logic [15:0] SYNC_MARK        = 16'h0B77;
  localparam logic [11:0] POS_MAX          = 12'hFFF;
  localparam logic [4:0]  RATE_CODES       = 5'd19;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SYNC  = 2'd1,
    ST_BAD_CODE = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_HEADER = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] sync_offset;
    logic [15:0] sample_rate_hz;
    logic [9:0]  bitrate_kbps;
    logic [11:0] frame_bytes;
    logic [2:0]  channel_count;
  } out_word_t;

  // Classified buffer outcome handed from the parser to the decoder.
  typedef struct packed {
    status_t     kind;
    logic [11:0] sync_pos;
    logic [7:0]  rate_byte;
    logic [2:0]  acmod;
  } job_t;

  function automatic logic [9:0] bitrate_of(input logic [4:0] rc);
    logic [9:0] br;
    case (rc)
      5'd0:    br = 10'd32;
      5'd1:    br = 10'd40;
      5'd2:    br = 10'd48;
      5'd3:    br = 10'd56;
      5'd4:    br = 10'd64;
      5'd5:    br = 10'd80;
      5'd6:    br = 10'd96;
      5'd7:    br = 10'd112;
      5'd8:    br = 10'd128;
      5'd9:    br = 10'd160;
      5'd10:   br = 10'd192;
      5'd11:   br = 10'd224;
      5'd12:   br = 10'd256;
      5'd13:   br = 10'd320;
      5'd14:   br = 10'd384;
      5'd15:   br = 10'd448;
      5'd16:   br = 10'd512;
      5'd17:   br = 10'd576;
      5'd18:   br = 10'd640;
      default: br = 10'd0;
    endcase
    return br;
  endfunction

  // 16-bit words per frame at 44.1 kHz, before padding
  function automatic logic [10:0] words_441(input logic [4:0] rc);
    logic [10:0] w;
    case (rc)
      5'd0:    w = 11'd69;
      5'd1:    w = 11'd87;
      5'd2:    w = 11'd104;
      5'd3:    w = 11'd121;
      5'd4:    w = 11'd139;
      5'd5:    w = 11'd174;
      5'd6:    w = 11'd208;
      5'd7:    w = 11'd243;
      5'd8:    w = 11'd278;
      5'd9:    w = 11'd348;
      5'd10:   w = 11'd417;
      5'd11:   w = 11'd487;
      5'd12:   w = 11'd557;
      5'd13:   w = 11'd696;
      5'd14:   w = 11'd835;
      5'd15:   w = 11'd975;
      5'd16:   w = 11'd1114;
      5'd17:   w = 11'd1253;
      5'd18:   w = 11'd1393;
      default: w = 11'd0;
    endcase
    return w;
  endfunction

  // Full-band channels per acmod, already raised to at least two
  function automatic logic [2:0] channels_of(input logic [2:0] acmod);
    logic [2:0] ch;
    case (acmod)
      3'd0, 3'd1, 3'd2: ch = 3'd2;
      3'd3, 3'd4:       ch = 3'd3;
      3'd5, 3'd6:       ch = 3'd4;
      default:          ch = 3'd5;
    endcase
    return ch;
  endfunction

  function automatic out_word_t decode_job(input job_t job);
    out_word_t   res;
    logic [1:0]  fs;
    logic [4:0]  rc;
    logic [9:0]  br;
    logic [10:0] words;
    res = '0;
    fs  = job.rate_byte[7:6];
    rc  = job.rate_byte[5:1];
    br  = bitrate_of(rc);
    words = '0;
    if (job.kind != ST_OK) begin
      res.status = job.kind;
    end else if (fs == 2'd3 || rc inside {[RATE_CODES:5'd31]}) begin
      res.status = ST_BAD_CODE;
    end else begin
      case (fs)
        2'd0: begin
          res.sample_rate_hz = 16'd48000;
          words = {1'b0, br};
        end
        2'd1: begin
          res.sample_rate_hz = 16'd44100;
          words = words_441(rc) + {10'd0, job.rate_byte[0]};
        end
        default: begin
          res.sample_rate_hz = 16'd32000;
          words = 11'(12'(br) * 12'd3);
        end
      endcase
      if (fs == 2'd0) begin
        words = {br, 1'b0};
      end
      res.status        = ST_OK;
      res.sync_offset   = job.sync_pos;
      res.bitrate_kbps  = br;
      res.frame_bytes   = {words, 1'b0};
      res.channel_count = channels_of(job.acmod);
    end
    return res;
  endfunction

endpackage

/* src/ac3_shp_front.sv */
`timescale 1ns / 1ps
// Byte parser: sync search, header capture and per-buffer outcome classification.
// Depends on ac3_shp_pkg.
module ac3_shp_front #(
  parameter int BUFFER_BYTES = ac3_shp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_valid,
  input  ac3_shp_pkg::in_word_t byte_word,
  output logic                  job_push,
  output ac3_shp_pkg::job_t     job
);
  import ac3_shp_pkg::*;

  localparam logic [31:0] WIN_LIMIT = 32'(BUFFER_BYTES - 4);

  logic [15:0] shift_r, shift_nxt;
  logic [11:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [7:0]  rate_r, rate_nxt;
  logic [11:0] syncpos_r, syncpos_nxt;
  logic        in_window;

  assign in_window = {20'd0, pos_r} < WIN_LIMIT;

  always_comb begin
    shift_nxt   = shift_r;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    hc_nxt      = hc_r;
    rate_nxt    = rate_r;
    syncpos_nxt = syncpos_r;
    job_push    = 1'b0;
    job         = '0;
    if (byte_valid) begin
      case (phase_r)
        PH_SEARCH: begin
          shift_nxt = {shift_r[7:0], byte_word.data_byte};
          if (shift_nxt == SYNC_MARK && in_window) begin
            syncpos_nxt = pos_r;
            hc_nxt      = 3'd0;
            phase_nxt   = PH_HEADER;
          end
        end
        PH_HEADER: begin
          hc_nxt = hc_r + 3'd1;
          if (hc_nxt == 3'd3) begin
            rate_nxt = byte_word.data_byte;
          end
          if (hc_nxt >= 3'd5) begin
            job_push      = 1'b1;
            job.kind      = ST_OK;
            job.sync_pos  = syncpos_r;
            job.rate_byte = rate_r;
            job.acmod     = byte_word.data_byte[7:5];
            phase_nxt     = PH_DONE;
          end
        end
        default: ;
      endcase
      if (byte_word.last_byte) begin
        // close out the buffer if nothing was reported, then rearm
        if (!job_push && phase_nxt == PH_SEARCH) begin
          job_push = 1'b1;
          job.kind = ST_NO_SYNC;
        end else if (!job_push && phase_nxt == PH_HEADER) begin
          job_push = 1'b1;
          job.kind = ST_TRUNC;
        end
        shift_nxt   = '0;
        pos_nxt     = '0;
        phase_nxt   = PH_SEARCH;
        hc_nxt      = '0;
        rate_nxt    = '0;
        syncpos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      pos_r     <= '0;
      phase_r   <= PH_SEARCH;
      hc_r      <= '0;
      rate_r    <= '0;
      syncpos_r <= '0;
    end else begin
      shift_r   <= shift_nxt;
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
      hc_r      <= hc_nxt;
      rate_r    <= rate_nxt;
      syncpos_r <= syncpos_nxt;
    end
  end

`ifndef SYNTH
  a_push_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> byte_valid)
    else $error("job pushed without an accepted byte");
  a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && byte_word.last_byte |=> phase_r == PH_SEARCH && pos_r == 12'd0)
    else $error("parser did not rearm after last byte");
  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> hc_r <= 3'd4)
    else $error("header count ran past acmod byte");
`endif

endmodule

/* src/ac3_shp_fifo.sv */
`timescale 1ns / 1ps
// Short job queue between parser and decoder.
// Depends on ac3_shp_pkg.
module ac3_shp_fifo #(
  parameter int DEPTH = ac3_shp_pkg::JOB_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ac3_shp_pkg::job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output ac3_shp_pkg::job_t head
);
  import ac3_shp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CNT_FULL;
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/ac3_shp_back.sv */
`timescale 1ns / 1ps
// Decoder: turns a queued job into a result word and holds it in the output register.
// Depends on ac3_shp_pkg.
module ac3_shp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_empty,
  input  ac3_shp_pkg::job_t      job,
  output logic                   job_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output ac3_shp_pkg::out_word_t out_data
);
  import ac3_shp_pkg::*;

  logic      valid_r, valid_nxt;
  out_word_t res_r;
  logic      taken;

  assign taken     = out_pop && valid_r;
  assign job_pop   = !job_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_data  = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (job_pop) begin
      valid_nxt = 1'b1;
    end else if (taken) begin
      valid_nxt = 1'b0;
    end
  end

  // load the next word when none is held or as the held one leaves
  always_ff @(posedge clk) begin
    if (job_pop) begin
      res_r <= decode_job(job);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

`ifndef SYNTH
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.status != ST_OK |-> res_r.sync_offset == '0 &&
      res_r.sample_rate_hz == '0 && res_r.bitrate_kbps == '0 &&
      res_r.frame_bytes == '0 && res_r.channel_count == '0)
    else $error("error word carries nonzero fields");
  a_ok_channels: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.status == ST_OK |-> res_r.channel_count >= 3'd2)
    else $error("channel count below two");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_pop |=> valid_r && $stable(res_r))
    else $error("held result word overwritten");
`endif

endmodule

/* src/ac3_sync_header_probe_core.sv */
`timescale 1ns / 1ps
// Top level of the AC-3 sync header probe: parser, job queue and decoder.
// Depends on ac3_shp_pkg, ac3_shp_front, ac3_shp_fifo, ac3_shp_back.
//
//   channel | handshake          | word
//   --------+--------------------+----------------------------------------------
//   in      | in_push / in_full  | data_byte, last_byte
//   out     | out_pop / out_empty| status, offset, rate, bitrate, frame, chans
//
// One byte per cycle enters while in_full is low; the parser updates its state in that cycle.
// Once its deciding byte is taken, a buffer's result word is registered first
// in the job queue and then in the decoder's output register.
// Reset (rst_n low, synchronous) empties the queue and rearms the search.
// in_full follows the job queue (JOB_DEPTH entries); a stalled out side
// only stops input once the queue fills.
module ac3_sync_header_probe_core #(
  parameter int BUFFER_BYTES = ac3_shp_pkg::BUFFER_BYTES_DEF,
  parameter int JOB_DEPTH    = ac3_shp_pkg::JOB_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  ac3_shp_pkg::in_word_t  in_data,
  output logic                   out_empty,
  input  logic                   out_pop,
  output ac3_shp_pkg::out_word_t out_data
);
  import ac3_shp_pkg::*;

  logic byte_valid;
  logic job_push, job_full, job_empty, job_pop;
  job_t push_job, head_job;

  assign in_full    = job_full;
  assign byte_valid = in_push && !job_full;

  ac3_shp_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_valid),
    .byte_word (in_data),
    .job_push  (job_push),
    .job       (push_job)
  );

  ac3_shp_fifo #(
    .DEPTH(JOB_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .push_job(push_job),
    .full    (job_full),
    .pop     (job_pop),
    .empty   (job_empty),
    .head    (head_job)
  );

  ac3_shp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job      (head_job),
    .job_pop  (job_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule

/* dv/ac3_shp_header_check.sv */
`timescale 1ns / 1ps
// Scoreboard for the AC-3 sync header probe: tracks accepted bytes, predicts the
// per-buffer header word and compares it with each popped result. Depends on ac3_shp_pkg.
module ac3_shp_header_check #(
  parameter int BUFFER_BYTES = ac3_shp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic                   in_full,
  input  ac3_shp_pkg::in_word_t  in_data,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  ac3_shp_pkg::out_word_t out_data,
  output int                     mismatches,
  output int                     pending
);
  import ac3_shp_pkg::*;

  logic [15:0] shift_reg;
  logic [11:0] byte_idx;
  phase_t      phase;
  logic [2:0]  hdr_seen;
  logic [7:0]  rate_byte;
  logic [11:0] sync_idx;

  out_word_t awaited_headers[$];
  out_word_t fresh;
  out_word_t oldest;
  int        bad_words = 0;
  int        waiting = 0;

  assign mismatches = bad_words;
  assign pending    = waiting;

  function automatic int kbps_for(input int code);
    case (code)
      0: return 32;    1: return 40;    2: return 48;    3: return 56;
      4: return 64;    5: return 80;    6: return 96;    7: return 112;
      8: return 128;   9: return 160;   10: return 192;  11: return 224;
      12: return 256;  13: return 320;  14: return 384;  15: return 448;
      16: return 512;  17: return 576;  default: return 640;
    endcase
  endfunction

  function automatic int chans_for(input logic [2:0] acmod);
    case (acmod)
      3'd0: return 2;
      3'd1: return 1;
      3'd2: return 2;
      3'd3, 3'd4: return 3;
      3'd5, 3'd6: return 4;
      default: return 5;
    endcase
  endfunction

  function automatic out_word_t decode_header(input logic [7:0] rb, input logic [7:0] ab,
                                              input logic [11:0] pos);
    out_word_t w;
    int fs;
    int rc;
    int hz;
    int kbps;
    int words;
    int chans;
    w  = '0;
    fs = rb[7:6];
    rc = rb[5:1];
    if (fs == 3 || rc >= 19) begin
      w.status = ST_BAD_CODE;
      return w;
    end
    hz    = (fs == 0) ? 48000 : (fs == 1) ? 44100 : 32000;
    kbps  = kbps_for(rc);
    words = kbps * 96000 / hz;
    if (hz == 44100) words += rb[0];
    chans = chans_for(ab[7:5]);
    if (chans < 2) chans = 2;
    w.status         = ST_OK;
    w.sync_offset    = pos;
    w.sample_rate_hz = 16'(hz);
    w.bitrate_kbps   = 10'(kbps);
    w.frame_bytes    = 12'(2 * words);
    w.channel_count  = 3'(chans);
    return w;
  endfunction

  function void clear_parser();
    shift_reg = '0;
    byte_idx  = '0;
    phase     = PH_SEARCH;
    hdr_seen  = '0;
    rate_byte = '0;
    sync_idx  = '0;
  endfunction

  // Advance the parser by one byte; returns 1 when the byte closes out a buffer word.
  function bit scan_byte(input in_word_t w, output out_word_t res);
    bit got;
    got = 1'b0;
    res = '0;
    case (phase)
      PH_SEARCH: begin
        shift_reg = {shift_reg[7:0], w.data_byte};
        if (shift_reg == SYNC_MARK && int'(byte_idx) < BUFFER_BYTES - 4) begin
          sync_idx = byte_idx;
          hdr_seen = '0;
          phase    = PH_HEADER;
        end
      end
      PH_HEADER: begin
        hdr_seen = hdr_seen + 3'd1;
        if (hdr_seen == 3'd3) rate_byte = w.data_byte;
        if (hdr_seen >= 3'd5) begin
          res   = decode_header(rate_byte, w.data_byte, sync_idx);
          got   = 1'b1;
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (w.last_byte) begin
      // close out a buffer that never produced its word
      if (!got && phase != PH_DONE) begin
        res        = '0;
        res.status = (phase == PH_SEARCH) ? ST_NO_SYNC : ST_TRUNC;
        got        = 1'b1;
      end
      clear_parser();
    end else if (byte_idx != POS_MAX) begin
      byte_idx = byte_idx + 12'd1;
    end
    return got;
  endfunction

  task automatic note_mismatch(input out_word_t e, input out_word_t a);
    bad_words++;
    if (bad_words <= 10) begin
      $display("%0t mismatch: expected st=%0d off=%0d hz=%0d kbps=%0d bytes=%0d ch=%0d",
               $realtime, e.status, e.sync_offset, e.sample_rate_hz, e.bitrate_kbps,
               e.frame_bytes, e.channel_count);
      $display("%0t           actual st=%0d off=%0d hz=%0d kbps=%0d bytes=%0d ch=%0d",
               $realtime, a.status, a.sync_offset, a.sample_rate_hz, a.bitrate_kbps,
               a.frame_bytes, a.channel_count);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      awaited_headers.delete();
    end else begin
      if (in_push && !in_full) begin
        if (scan_byte(in_data, fresh)) awaited_headers.push_back(fresh);
      end
      if (out_pop && !out_empty) begin
        if (awaited_headers.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t unexpected word: st=%0d off=%0d hz=%0d kbps=%0d bytes=%0d ch=%0d",
                     $realtime, out_data.status, out_data.sync_offset,
                     out_data.sample_rate_hz, out_data.bitrate_kbps, out_data.frame_bytes,
                     out_data.channel_count);
        end else begin
          oldest = awaited_headers.pop_front();
          if (out_data.status !== oldest.status ||
              out_data.sync_offset !== oldest.sync_offset ||
              out_data.sample_rate_hz !== oldest.sample_rate_hz ||
              out_data.bitrate_kbps !== oldest.bitrate_kbps ||
              out_data.frame_bytes !== oldest.frame_bytes ||
              out_data.channel_count !== oldest.channel_count)
            note_mismatch(oldest, out_data);
        end
      end
    end
    waiting = awaited_headers.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the AC-3 sync header probe bench: clock, reset, byte-buffer stimulus and
// result draining. Depends on ac3_shp_pkg, ac3_sync_header_probe_core, ac3_shp_header_check.
module testbench;
  import ac3_shp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 1450;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_word_t  in_data = '0;
  logic      out_pop = 1'b0;
  logic      in_full;
  logic      out_empty;
  out_word_t out_data;
  int        mismatches;
  int        pending;

  int         sent_n = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;
  bit         hold_request = 1'b0;
  logic [7:0] bytes_q[$];

  always #5 clk = ~clk;

  ac3_sync_header_probe_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  ac3_shp_header_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  function automatic int pick_wait(input bit calm);
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= {b, fin};
    do @(posedge clk); while (in_full);
    @(negedge clk);
    sent_n++;
  endtask

  task automatic ship_buffer();
    foreach (bytes_q[i]) send_word(bytes_q[i], i == bytes_q.size() - 1);
    bytes_q.delete();
    if ($urandom_range(0, 7) == 0) tx_calm = !tx_calm;
  endtask

  // clean junk never carries the first sync byte, so it cannot form a sync word
  task automatic add_junk(input int n, input bit clean);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (clean && b == SYNC_MARK[15:8]) b = 8'h0A;
      bytes_q.push_back(b);
    end
  endtask

  task automatic add_sync();
    bytes_q.push_back(SYNC_MARK[15:8]);
    bytes_q.push_back(SYNC_MARK[7:0]);
  endtask

  task automatic add_frame(input logic [7:0] rate, input logic [7:0] acmod_byte);
    add_sync();
    add_junk(2, 1'b0);
    bytes_q.push_back(rate);
    add_junk(1, 1'b0);
    bytes_q.push_back(acmod_byte);
  endtask

  function automatic logic [7:0] pick_rate();
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1) == 1) return {2'b11, 6'($urandom_range(0, 63))};
      return {2'($urandom_range(0, 2)), 5'($urandom_range(19, 31)), 1'($urandom_range(0, 1))};
    end
    return {2'($urandom_range(0, 2)), 5'($urandom_range(0, 18)), 1'($urandom_range(0, 1))};
  endfunction

  // result side: random pops, plus one long hold-off to back the queue up
  initial begin
    int gap;
    repeat (5) @(negedge clk);
    forever begin
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = pick_wait(rx_calm);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    bit pressed;
    int kind;
    int random_start;
    pressed = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    bytes_q.push_back(8'hFF);
    ship_buffer();                   // no sync at all
    add_sync();
    ship_buffer();                   // sync word ends on the last byte
    add_frame(8'hFF, 8'h00);
    ship_buffer();                   // reserved sample-rate code
    add_frame(8'h00, 8'h20);
    ship_buffer();                   // 48 kHz lowest bitrate, mono raised to two
    add_frame(8'h65, 8'hFF);
    ship_buffer();                   // 44.1 kHz top bitrate with pad, 3/2 mode

    random_start = sent_n;
    while (sent_n - random_start < ITEM_TARGET) begin
      if (!pressed && sent_n - random_start > 600) begin
        pressed      = 1'b1;
        hold_request = 1'b1;
        repeat (16) begin
          add_junk(1, 1'b0);
          ship_buffer();
        end
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        add_junk($urandom_range(0, 6), 1'b0);
        add_frame(pick_rate(), 8'($urandom_range(0, 255)));
        add_junk($urandom_range(0, 4), 1'b0);
      end else if (kind < 72) begin
        // cut the header short
        add_junk($urandom_range(0, 4), 1'b0);
        add_sync();
        if ($urandom_range(0, 1) == 1) begin
          add_junk(2, 1'b0);
          bytes_q.push_back(pick_rate());
          add_junk($urandom_range(0, 1), 1'b0);
        end else begin
          add_junk($urandom_range(0, 4), 1'b0);
        end
      end else if (kind < 84) begin
        add_junk($urandom_range(1, 12), 1'b0);
      end else if (kind < 92) begin
        add_junk(1, 1'b0);
      end else if (kind < 99) begin
        // reversed and doubled sync bytes ahead of a real frame
        bytes_q.push_back(SYNC_MARK[7:0]);
        bytes_q.push_back(SYNC_MARK[15:8]);
        bytes_q.push_back(SYNC_MARK[15:8]);
        add_frame(pick_rate(), 8'($urandom_range(0, 255)));
      end else begin
        add_junk($urandom_range(8, 600), 1'b1);
        add_frame(pick_rate(), 8'($urandom_range(0, 255)));
        add_junk($urandom_range(0, 3), 1'b0);
      end
      ship_buffer();
    end
    in_push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
